### hdl/pfba_pkg.sv
// ----------------------------------------------------------------------------
// pfba_pkg
// Shared types, sizes and helpers of the page frame bitmap allocator.
// ----------------------------------------------------------------------------
package pfba_pkg;

   localparam int PAGE_COUNT = 1048576;
   localparam int FRAME_W    = 20;
   localparam int WORD_W     = 32;
   localparam int MAP_WORDS  = PAGE_COUNT / 32;
   localparam int MAP_AW     = 15;
   localparam int SUM_WORDS  = MAP_WORDS / 32;
   localparam int SUM_AW     = 10;
   localparam int MID_WORDS  = SUM_WORDS / 32;
   localparam int MID_AW     = 5;

   typedef enum logic [1:0] {
      OP_ENABLE  = 2'd0,
      OP_DISABLE = 2'd1,
      OP_ALLOC   = 2'd2,
      OP_FREE    = 2'd3
   } op_type;

   typedef enum logic [6:0] {
      ST_CLEAR = 7'b0000001,
      ST_IDLE  = 7'b0000010,
      ST_MID   = 7'b0000100,
      ST_SUM   = 7'b0001000,
      ST_RD    = 7'b0010000,
      ST_MOD   = 7'b0100000,
      ST_DONE  = 7'b1000000
   } state_type;

   // index of the lowest set bit, zero when none
   function automatic logic [4:0] lowest_set(input logic [31:0] v);
      logic [4:0] idx;
      idx = 5'd0;
      for (int i = 31; i >= 0; i--) begin
         if (v[i]) begin
            idx = 5'(i);
         end
      end
      return idx;
   endfunction

endpackage

### hdl/pfba_ram.sv
// ----------------------------------------------------------------------------
// pfba_ram
// Generic single-port synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module pfba_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end else begin
         rdata_ff <= mem[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

### hdl/page_frame_bitmap_allocator.sv
// ----------------------------------------------------------------------------
// page_frame_bitmap_allocator
// First-fit bitmap allocator of 4 KiB page frames, one free bit per frame.
// ----------------------------------------------------------------------------
//  channel | ports                                             | direction
//  request | req_valid req_ready req_opcode req_base_address  | in
//          | req_range_length req_frame_to_free                |
//  result  | rsp_valid rsp_ready rsp_frame_number rsp_ok       | out
//
//  after reset a clearing pass zeroes the map and both summary RAMs; no transfer
//  free: map word read-modify-write; allocate: mid and summary word reads,
//  then map word read-modify-write; ranges: one read-modify-write per map word
//  a three-level summary (32-bit register over a 32-word mid RAM over a
//  1024-word summary RAM) finds the lowest free word
//  a waiting result stalls only the final step; the next request is then held
// ----------------------------------------------------------------------------
module page_frame_bitmap_allocator
   import pfba_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_opcode,
   input  logic [31:0]        req_base_address,
   input  logic [31:0]        req_range_length,
   input  logic [FRAME_W-1:0] req_frame_to_free,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [FRAME_W-1:0] rsp_frame_number,
   output logic               rsp_ok
);

   state_type state_ff, state_in;
   op_type    op_ff, op_in;
   logic [FRAME_W:0]   cur_ff, cur_in;
   logic [FRAME_W:0]   hi_ff, hi_in;
   logic [4:0]         grp_ff, grp_in;
   logic [MAP_AW-1:0]  clr_ff, clr_in;
   logic [31:0]        top_ff, top_in;
   logic [FRAME_W-1:0] res_frame_ff, res_frame_in;
   logic               res_ok_ff, res_ok_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [FRAME_W-1:0] rsp_frame_ff, rsp_frame_in;
   logic               rsp_ok_ff, rsp_ok_in;

   logic               map_we, sum_we, mid_we;
   logic [MAP_AW-1:0]  map_addr;
   logic [SUM_AW-1:0]  sum_addr;
   logic [MID_AW-1:0]  mid_addr;
   logic [WORD_W-1:0]  map_wdata, map_rdata, sum_wdata, sum_rdata;
   logic [WORD_W-1:0]  mid_wdata, mid_rdata;

   logic               req_xfer;
   logic [33:0]        end_sum;
   logic [21:0]        end_frame;
   logic [FRAME_W:0]   first_frame;
   logic [FRAME_W:0]   next_cur;
   logic [WORD_W-1:0]  mask, map_new, sum_new, mid_new, low_mask;
   logic [4:0]         low_bit;

   pfba_ram #(.WIDTH(WORD_W), .DEPTH(MAP_WORDS)) u_map (
      .clock(clock), .we(map_we), .addr(map_addr), .wdata(map_wdata), .rdata(map_rdata)
   );

   pfba_ram #(.WIDTH(WORD_W), .DEPTH(SUM_WORDS)) u_sum (
      .clock(clock), .we(sum_we), .addr(sum_addr), .wdata(sum_wdata), .rdata(sum_rdata)
   );

   pfba_ram #(.WIDTH(WORD_W), .DEPTH(MID_WORDS)) u_mid (
      .clock(clock), .we(mid_we), .addr(mid_addr), .wdata(mid_wdata), .rdata(mid_rdata)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign req_xfer  = req_valid && req_ready;

   assign end_sum     = 34'(req_base_address) + 34'(req_range_length) + 34'd4095;
   assign end_frame   = end_sum[33:12];
   assign first_frame = {1'b0, req_base_address[31:12]};

   assign low_bit  = lowest_set(map_rdata);
   assign low_mask = 32'd1 << low_bit;
   assign next_cur = {cur_ff[FRAME_W:5] + 16'd1, 5'd0};

   always_comb begin
      mask = '0;
      case (op_ff)
         OP_ENABLE, OP_DISABLE: begin
            mask = 32'hFFFF_FFFF << cur_ff[4:0];
            if (hi_ff[FRAME_W:5] == cur_ff[FRAME_W:5]) begin
               mask = mask & ((32'd1 << hi_ff[4:0]) - 32'd1);
            end
         end
         OP_ALLOC: mask = low_mask;
         OP_FREE:  mask = 32'd1 << cur_ff[4:0];
         default:  mask = '0;
      endcase
      if (op_ff == OP_DISABLE || op_ff == OP_ALLOC) begin
         map_new = map_rdata & ~mask;
      end else begin
         map_new = map_rdata | mask;
      end
      sum_new = sum_rdata;
      sum_new[cur_ff[9:5]] = (map_new != '0);
      mid_new = mid_rdata;
      mid_new[cur_ff[14:10]] = (sum_new != '0);
   end

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      cur_in       = cur_ff;
      hi_in        = hi_ff;
      grp_in       = grp_ff;
      clr_in       = clr_ff;
      top_in       = top_ff;
      res_frame_in = res_frame_ff;
      res_ok_in    = res_ok_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_frame_in = rsp_frame_ff;
      rsp_ok_in    = rsp_ok_ff;
      map_we       = 1'b0;
      sum_we       = 1'b0;
      mid_we       = 1'b0;
      map_addr     = cur_ff[FRAME_W-1:5];
      sum_addr     = cur_ff[FRAME_W-1:10];
      mid_addr     = cur_ff[FRAME_W-1:15];
      map_wdata    = map_new;
      sum_wdata    = sum_new;
      mid_wdata    = mid_new;

      case (state_ff)
         ST_CLEAR: begin
            map_we    = 1'b1;
            map_addr  = clr_ff;
            map_wdata = '0;
            sum_we    = (clr_ff < MAP_AW'(SUM_WORDS));
            sum_addr  = clr_ff[SUM_AW-1:0];
            sum_wdata = '0;
            mid_we    = (clr_ff < MAP_AW'(MID_WORDS));
            mid_addr  = clr_ff[MID_AW-1:0];
            mid_wdata = '0;
            clr_in    = clr_ff + MAP_AW'(1);
            if (clr_ff == MAP_AW'(MAP_WORDS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_xfer) begin
               op_in        = op_type'(req_opcode);
               res_frame_in = '0;
               res_ok_in    = 1'b1;
               case (op_type'(req_opcode))
                  OP_ENABLE, OP_DISABLE: begin
                     cur_in = first_frame;
                     if (end_frame > 22'(PAGE_COUNT)) begin
                        hi_in     = (FRAME_W+1)'(PAGE_COUNT);
                        res_ok_in = 1'b0;
                     end else begin
                        hi_in = end_frame[FRAME_W:0];
                     end
                     if (first_frame < hi_in) begin
                        state_in = ST_RD;
                     end else begin
                        state_in = ST_DONE;
                     end
                  end
                  OP_ALLOC: begin
                     grp_in   = lowest_set(top_ff);
                     mid_addr = lowest_set(top_ff);
                     if (top_ff == '0) begin
                        res_ok_in = 1'b0;
                        state_in  = ST_DONE;
                     end else begin
                        state_in = ST_MID;
                     end
                  end
                  OP_FREE: begin
                     cur_in = {1'b0, req_frame_to_free};
                     if ({1'b0, req_frame_to_free} < (FRAME_W+1)'(PAGE_COUNT)) begin
                        state_in = ST_RD;
                     end else begin
                        res_ok_in = 1'b0;
                        state_in  = ST_DONE;
                     end
                  end
                  default: state_in = ST_DONE;
               endcase
            end
         end
         ST_MID: begin
            sum_addr = {grp_ff, lowest_set(mid_rdata)};
            cur_in   = {1'b0, grp_ff, lowest_set(mid_rdata), 10'd0};
            state_in = ST_SUM;
         end
         ST_SUM: begin
            cur_in   = {cur_ff[FRAME_W:10], lowest_set(sum_rdata), 5'd0};
            state_in = ST_RD;
         end
         ST_RD: begin
            state_in = ST_MOD;
         end
         ST_MOD: begin
            map_we = 1'b1;
            sum_we = 1'b1;
            mid_we = 1'b1;
            top_in[cur_ff[FRAME_W-1:15]] = (mid_new != '0);
            if (op_ff == OP_ALLOC) begin
               res_frame_in = {cur_ff[FRAME_W-1:5], low_bit};
            end
            if ((op_ff == OP_ENABLE || op_ff == OP_DISABLE) && next_cur < hi_ff) begin
               cur_in   = next_cur;
               state_in = ST_RD;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_frame_in = res_frame_ff;
               rsp_ok_in    = res_ok_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         top_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         top_ff       <= top_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff        <= op_in;
      cur_ff       <= cur_in;
      hi_ff        <= hi_in;
      grp_ff       <= grp_in;
      res_frame_ff <= res_frame_in;
      res_ok_ff    <= res_ok_in;
      rsp_frame_ff <= rsp_frame_in;
      rsp_ok_ff    <= rsp_ok_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_frame_number = rsp_frame_ff;
   assign rsp_ok           = rsp_ok_ff;

   // summary says the word has a free frame, so allocate must find one
   a_alloc_hit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MOD && op_ff == OP_ALLOC) |-> (map_rdata != '0))
      else $error("allocate read an empty map word");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ok) |-> (rsp_frame_number == '0))
      else $error("failed result carries a frame number");

   a_clear_quiet: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> (!req_ready && !rsp_valid))
      else $error("transfer during clearing pass");

endmodule
